>>> src/lcm_pkg.sv
// Link cost package: payload structs, register indexes, status codes and datapath widths.
// No dependencies; used by the top level, the checker and the testbench.
`default_nettype none

package lcm_pkg;

	typedef struct packed {
		logic [7:0]  metric_flags;
		logic [31:0] rtt_us;
		logic [31:0] bandwidth_kbps;
		logic [31:0] loss_parts;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] cost_value;
	} out_item_t;

	// configuration register indexes
	localparam logic [1:0] REG_REQUIRED_MASK   = 2'd0;
	localparam logic [1:0] REG_REFERENCE_BYTES = 2'd1;
	localparam logic [1:0] REG_QUANTUM_US      = 2'd2;
	localparam logic [1:0] REG_MAX_LINK_COST   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// datapath widths
	localparam int NUM1_W = 45;  // reference_bytes * 8000
	localparam int BASE_W = 46;  // serialisation time + rtt
	localparam int PROD_W = 66;  // base * 1e6, overflow above bit 63
	localparam int EFF_W  = 64;
	localparam int DEN2_W = 20;  // 1e6 - loss, never above 1e6

	localparam logic [NUM1_W-1:0] SER_SCALE = NUM1_W'(8000);
	localparam logic [31:0]       MILLION   = 32'd1000000;
	localparam logic [PROD_W-1:0] LOSS_SCALE = PROD_W'(1000000);

endpackage

`default_nettype wire

>>> src/lcm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband carried along.
// Depends on nothing; instantiated by the link cost top level.
`default_nettype none

module lcm_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int SW = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [SW-1:0] in_side,
	output logic               out_valid,
	output logic [NW-1:0]      out_quo,
	output logic [DW-1:0]      out_rem,
	output logic [SW-1:0]      out_side
);

	logic          vld_s  [NW];
	logic [NW-1:0] dq_s   [NW];  // dividend bits still to consume, quotient bits shifted in
	logic [DW-1:0] rem_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic          pv;
		logic [NW-1:0] pdq;
		logic [DW-1:0] prem;
		logic [DW-1:0] pden;
		logic [SW-1:0] pside;
		logic [DW:0]   part;
		logic          ge;
		logic [DW:0]   diff;

		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign pdq   = in_num;
			assign prem  = '0;
			assign pden  = in_den;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = vld_s[i-1];
			assign pdq   = dq_s[i-1];
			assign prem  = rem_s[i-1];
			assign pden  = den_s[i-1];
			assign pside = side_s[i-1];
		end

		assign part = {prem, pdq[NW-1]};
		assign ge   = part >= {1'b0, pden};
		assign diff = ge ? (part - {1'b0, pden}) : part;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[i]   <= {pdq[NW-2:0], ge};
				rem_s[i]  <= diff[DW-1:0];
				den_s[i]  <= pden;
				side_s[i] <= pside;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign out_quo   = dq_s[NW-1];
	assign out_rem   = rem_s[NW-1];
	assign out_side  = side_s[NW-1];

endmodule

`default_nettype wire

>>> src/link_cost_from_metrics_top.sv
// Link cost from one measurement, pipelined from input transfer to result valid.
// Throughput one item per cycle unless the pipeline is held; each of the three dividers
// retires one quotient bit per stage (45 + 64 + 64 stages) plus five arithmetic stages.
// The whole pipeline advances together; it holds while a result waits under out_stall.
// Reset (arst_n low, asynchronous) empties the pipeline and returns the registers to
// required_mask 7, reference_bytes 1500, quantum_us 100, max_link_cost 65535.
`default_nettype none

module link_cost_from_metrics_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// measurement channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire lcm_pkg::in_item_t  in_item,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output lcm_pkg::out_item_t      out_item,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int NUM1_W = lcm_pkg::NUM1_W;
	localparam int BASE_W = lcm_pkg::BASE_W;
	localparam int PROD_W = lcm_pkg::PROD_W;
	localparam int EFF_W  = lcm_pkg::EFF_W;
	localparam int DEN2_W = lcm_pkg::DEN2_W;

	// ---------------------------------------------------------------------
	// Configuration registers. Written by the user only while the pipeline is empty,
	// so every stage reads them live; the block itself does not enforce this.
	// ---------------------------------------------------------------------
	logic [7:0]  required_mask_q;
	logic [31:0] reference_bytes_q;
	logic [31:0] quantum_us_q;
	logic [31:0] max_link_cost_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_mask_q   <= 8'd7;
			reference_bytes_q <= 32'd1500;
			quantum_us_q      <= 32'd100;
			max_link_cost_q   <= 32'd65535;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcm_pkg::REG_REQUIRED_MASK:   required_mask_q   <= cfg_data[7:0];
				lcm_pkg::REG_REFERENCE_BYTES: reference_bytes_q <= cfg_data;
				lcm_pkg::REG_QUANTUM_US:      quantum_us_q      <= cfg_data;
				lcm_pkg::REG_MAX_LINK_COST:   max_link_cost_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Global advance: every stage moves when the output register is free or
	// being emptied this cycle.
	// ---------------------------------------------------------------------
	logic out_valid_q;
	logic adv;
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// ---------------------------------------------------------------------
	// Stage 1: validity checks, serialisation numerator, loss divisor.
	// ---------------------------------------------------------------------
	logic              inv_c;
	logic [31:0]       loss_gap_c;
	logic              v_s1;
	logic [NUM1_W-1:0] num1_s1;
	logic [31:0]       bw_s1;
	logic [31:0]       rtt_s1;
	logic [DEN2_W-1:0] den2_s1;
	logic              inv_s1;

	assign inv_c = (in_item.metric_flags != required_mask_q) || (in_item.rtt_us == '0) ||
		(in_item.bandwidth_kbps == '0) || (in_item.loss_parts >= lcm_pkg::MILLION);
	assign loss_gap_c = lcm_pkg::MILLION - in_item.loss_parts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_s1 <= NUM1_W'(reference_bytes_q) * lcm_pkg::SER_SCALE;
			// a zero divisor only occurs on invalid items; keep the divider sane
			bw_s1   <= (in_item.bandwidth_kbps == '0) ? 32'd1 : in_item.bandwidth_kbps;
			rtt_s1  <= in_item.rtt_us;
			den2_s1 <= inv_c ? DEN2_W'(1) : loss_gap_c[DEN2_W-1:0];
			inv_s1  <= inv_c;
		end
	end

	// ---------------------------------------------------------------------
	// Divider 1: serialisation time = ceil(bytes*8000 / bandwidth).
	// ---------------------------------------------------------------------
	localparam int SIDE1_W = 32 + DEN2_W + 1;
	logic               v_d1;
	logic [NUM1_W-1:0]  quo_d1;
	logic [31:0]        rem_d1;
	logic [SIDE1_W-1:0] side_d1;

	lcm_div #(.NW(NUM1_W), .DW(32), .SW(SIDE1_W)) u_div_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.in_num    (num1_s1),
		.in_den    (bw_s1),
		.in_side   ({rtt_s1, den2_s1, inv_s1}),
		.out_valid (v_d1),
		.out_quo   (quo_d1),
		.out_rem   (rem_d1),
		.out_side  (side_d1)
	);

	// ---------------------------------------------------------------------
	// Stage A: base = ceil of serialisation time + rtt (cannot overflow).
	// ---------------------------------------------------------------------
	logic              v_sA;
	logic [BASE_W-1:0] base_sA;
	logic [DEN2_W-1:0] den2_sA;
	logic              inv_sA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sA <= 1'b0;
		end else if (adv) begin
			v_sA <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_sA <= BASE_W'(quo_d1) + BASE_W'(rem_d1 != '0) +
				BASE_W'(side_d1[SIDE1_W-1 -: 32]);
			den2_sA <= side_d1[DEN2_W:1];
			inv_sA  <= side_d1[0];
		end
	end

	// ---------------------------------------------------------------------
	// Stage B: loss scaling product, exact at 66 bits.
	// ---------------------------------------------------------------------
	logic              v_sB;
	logic [PROD_W-1:0] prod_sB;
	logic [DEN2_W-1:0] den2_sB;
	logic              inv_sB;
	logic              ovf_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sB <= 1'b0;
		end else if (adv) begin
			v_sB <= v_sA;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_sB <= PROD_W'(base_sA) * lcm_pkg::LOSS_SCALE;
			den2_sB <= den2_sA;
			inv_sB  <= inv_sA;
		end
	end

	// anything above bit 63 is a 64-bit overflow
	assign ovf_c = |prod_sB[PROD_W-1:EFF_W];

	// ---------------------------------------------------------------------
	// Divider 2: effective time = ceil(product / (1e6 - loss)).
	// ---------------------------------------------------------------------
	logic             v_d2;
	logic [EFF_W-1:0] quo_d2;
	logic [DEN2_W-1:0] rem_d2;
	logic [1:0]       side_d2;

	lcm_div #(.NW(EFF_W), .DW(DEN2_W), .SW(2)) u_div_loss (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_sB),
		.in_num    (prod_sB[EFF_W-1:0]),
		.in_den    (den2_sB),
		.in_side   ({inv_sB, ovf_c}),
		.out_valid (v_d2),
		.out_quo   (quo_d2),
		.out_rem   (rem_d2),
		.out_side  (side_d2)
	);

	// ---------------------------------------------------------------------
	// Stage C: ceiling of effective time; quotient is never all ones here
	// with a nonzero remainder, so no carry out.
	// ---------------------------------------------------------------------
	logic             v_sC;
	logic [EFF_W-1:0] eff_sC;
	logic [1:0]       flags_sC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sC <= 1'b0;
		end else if (adv) begin
			v_sC <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eff_sC   <= quo_d2 + EFF_W'(rem_d2 != '0);
			flags_sC <= side_d2;
		end
	end

	// ---------------------------------------------------------------------
	// Divider 3: cost units = ceil(effective time / quantum). Zero quantum
	// is flagged at the output stage.
	// ---------------------------------------------------------------------
	logic             v_d3;
	logic [EFF_W-1:0] quo_d3;
	logic [31:0]      rem_d3;
	logic [1:0]       side_d3;

	lcm_div #(.NW(EFF_W), .DW(32), .SW(2)) u_div_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_sC),
		.in_num    (eff_sC),
		.in_den    ((quantum_us_q == '0) ? 32'd1 : quantum_us_q),
		.in_side   (flags_sC),
		.out_valid (v_d3),
		.out_quo   (quo_d3),
		.out_rem   (rem_d3),
		.out_side  (side_d3)
	);

	// ---------------------------------------------------------------------
	// Output stage: ceiling, clamp to 1..max (0 when max is 0), status priority
	// invalid input, then overflow, then zero quantum.
	// ---------------------------------------------------------------------
	logic [EFF_W-1:0]   units_c;
	logic [31:0]        clamp_c;
	lcm_pkg::out_item_t res_c;
	lcm_pkg::out_item_t out_item_q;

	assign units_c = quo_d3 + EFF_W'(rem_d3 != '0);

	always_comb begin
		if (units_c == '0) begin
			clamp_c = (max_link_cost_q == '0) ? 32'd0 : 32'd1;
		end else if (units_c > EFF_W'(max_link_cost_q)) begin
			clamp_c = max_link_cost_q;
		end else begin
			clamp_c = units_c[31:0];
		end
		res_c.cost_value = '0;
		if (side_d3[1]) begin
			res_c.status = lcm_pkg::ST_INVALID;
		end else if (side_d3[0]) begin
			res_c.status = lcm_pkg::ST_OVERFLOW;
		end else if (quantum_us_q == '0) begin
			res_c.status = lcm_pkg::ST_INVALID;
		end else begin
			res_c.status     = lcm_pkg::ST_OK;
			res_c.cost_value = clamp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

>>> src/lcm_chk.sv
// Port-level checker for the link cost block, bound to the top level.
// Depends on lcm_pkg and link_cost_from_metrics_top.
`default_nettype none

module lcm_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire lcm_pkg::out_item_t out_item
);

	// a waiting result is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// with nothing waiting at the output the block takes input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status == lcm_pkg::ST_OK ||
			out_item.status == lcm_pkg::ST_INVALID ||
			out_item.status == lcm_pkg::ST_OVERFLOW)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != lcm_pkg::ST_OK |-> out_item.cost_value == '0)
		else $error("nonzero cost on error status");

endmodule

bind link_cost_from_metrics_top lcm_chk u_lcm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

>>> verif/link_cost_from_metrics_top_tb.sv
// Self-checking testbench for link_cost_from_metrics_top: directed table then random
// measurements, checked against an in-bench cost calculator. Depends on lcm_pkg.
`default_nettype none

module link_cost_from_metrics_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT  = 178;
	localparam int CYC_LIMIT = 400000;
	localparam int N_RANDOM  = 1520;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	lcm_pkg::in_item_t  in_item = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	lcm_pkg::out_item_t out_item;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	link_cost_from_metrics_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// local copy of the registers
	logic [7:0]  m_mask;
	logic [31:0] m_ref_bytes, m_quantum, m_max_cost;

	lcm_pkg::out_item_t pending_costs[$];
	int        n_errors = 0;
	int        n_results = 0;
	int        n_sent = 0;
	int        n_ok = 0, n_inval = 0, n_ovf = 0;
	longint    cycle = 0;
	bit        calm = 1'b0;   // no idling on either side while set

	// expected cost for one measurement under the current registers
	function automatic lcm_pkg::out_item_t link_cost(lcm_pkg::in_item_t m);
		lcm_pkg::out_item_t r;
		logic [63:0]  ser, base, den, eff, units;
		logic [127:0] prod;
		r.status = lcm_pkg::ST_INVALID;
		r.cost_value = '0;
		if (m.metric_flags != m_mask || m.rtt_us == 0 || m.bandwidth_kbps == 0
				|| m.loss_parts >= lcm_pkg::MILLION)
			return r;
		ser  = (64'(m_ref_bytes) * 64'd8000 + 64'(m.bandwidth_kbps) - 64'd1)
			/ 64'(m.bandwidth_kbps);
		base = ser + 64'(m.rtt_us);
		prod = 128'(base) * 128'd1000000;
		if (prod[127:64] != 0) begin
			r.status = lcm_pkg::ST_OVERFLOW;
			return r;
		end
		den = 64'(lcm_pkg::MILLION) - 64'(m.loss_parts);
		eff = prod[63:0] / den + ((prod[63:0] % den) != 0);
		if (m_quantum == 0)
			return r;
		units = eff / 64'(m_quantum) + ((eff % 64'(m_quantum)) != 0);
		if (units < 1)
			units = 1;
		if (units > 64'(m_max_cost))
			units = 64'(m_max_cost);
		r.status = lcm_pkg::ST_OK;
		r.cost_value = units[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		n_errors++;
		$display("[%0t] result %0d: %s got %0h expected %0h", $realtime, n_results,
			what, got, want);
	endtask

	// result side: random stall, checks every transfer
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (arst_n) begin
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
			if (out_valid && !out_stall) begin
				lcm_pkg::out_item_t want;
				n_results++;
				if (pending_costs.size() == 0) begin
					report_mismatch("unexpected transfer", 64'(out_item), 0);
				end else begin
					want = pending_costs.pop_front();
					if (out_item.status != want.status)
						report_mismatch("status", out_item.status, want.status);
					if (out_item.cost_value != want.cost_value)
						report_mismatch("cost_value", out_item.cost_value, want.cost_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle >= CYC_LIMIT) begin
			$display("timeout at cycle %0d, %0d results outstanding", cycle,
				pending_costs.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one measurement transfer, with random idle cycles ahead of it;
	// valid stays up afterwards until the next idle cycle or drain
	task automatic send_measurement(lcm_pkg::in_item_t m, bit has_want,
			lcm_pkg::out_item_t want);
		lcm_pkg::out_item_t pred;
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= m;
		do @(posedge clk); while (in_stall);
		pred = link_cost(m);
		if (has_want && pred != want)
			report_mismatch("directed table vs calculator", 64'(pred), 64'(want));
		pending_costs.push_back(has_want ? want : pred);
		case (pred.status)
			lcm_pkg::ST_OK:      n_ok++;
			lcm_pkg::ST_INVALID: n_inval++;
			default:             n_ovf++;
		endcase
		n_sent++;
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lcm_pkg::REG_REQUIRED_MASK:   m_mask = val[7:0];
			lcm_pkg::REG_REFERENCE_BYTES: m_ref_bytes = val;
			lcm_pkg::REG_QUANTUM_US:      m_quantum = val;
			default:                      m_max_cost = val;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_costs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0:       return $urandom_range(20);
			1:       return 32'hFFFF_FFFF - $urandom_range(20);
			2:       return $urandom_range(1_000_000);
			default: return $urandom;
		endcase
	endfunction

	typedef struct {
		lcm_pkg::in_item_t  m;
		bit                 has_want;
		lcm_pkg::out_item_t want;
	} stim_row_t;

	stim_row_t dir_rows[$];

	function automatic stim_row_t row(logic [7:0] f, logic [31:0] rtt, logic [31:0] bw,
			logic [31:0] loss, bit hw = 0, logic [1:0] st = lcm_pkg::ST_OK,
			logic [31:0] c = 0);
		stim_row_t s;
		s.m = '{metric_flags: f, rtt_us: rtt, bandwidth_kbps: bw, loss_parts: loss};
		s.has_want = hw;
		s.want = '{status: st, cost_value: c};
		return s;
	endfunction

	// random measurement: mostly well formed so the datapath is exercised
	function automatic lcm_pkg::in_item_t rand_measurement();
		lcm_pkg::in_item_t m;
		m.metric_flags   = ($urandom_range(9) == 0) ? 8'($urandom) : m_mask;
		m.rtt_us         = rand_word();
		m.bandwidth_kbps = rand_word();
		m.loss_parts     = ($urandom_range(9) == 0) ? rand_word()
			: (($urandom_range(3) == 0) ? 32'd999_999 - $urandom_range(50)
			: $urandom_range(999_999));
		if ($urandom_range(30) == 0) m.rtt_us = 0;
		if ($urandom_range(30) == 0) m.bandwidth_kbps = 0;
		return m;
	endfunction

	initial begin
		m_mask = 8'd7; m_ref_bytes = 32'd1500; m_quantum = 32'd100; m_max_cost = 32'd65535;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, invalid cases, extremes
		// 1500 B at 12000 kbps -> 1000 us, +1000 rtt, no loss -> 20 units
		dir_rows.push_back(row(8'd7, 32'd1000, 32'd12000, 32'd0, 1, lcm_pkg::ST_OK, 32'd20));
		dir_rows.push_back(row(8'd6, 32'd1000, 32'd12000, 32'd0, 1, lcm_pkg::ST_INVALID, 0));
		dir_rows.push_back(row(8'hFF, 32'd1000, 32'd12000, 32'd0, 1, lcm_pkg::ST_INVALID, 0));
		dir_rows.push_back(row(8'd7, 32'd0, 32'd12000, 32'd0, 1, lcm_pkg::ST_INVALID, 0));
		dir_rows.push_back(row(8'd7, 32'd1000, 32'd0, 32'd0, 1, lcm_pkg::ST_INVALID, 0));
		dir_rows.push_back(row(8'd7, 32'd1000, 32'd12000, 32'd1000000, 1,
			lcm_pkg::ST_INVALID, 0));
		dir_rows.push_back(row(8'd7, 32'd1000, 32'd12000, 32'hFFFF_FFFF, 1,
			lcm_pkg::ST_INVALID, 0));
		// tiny values round up to one unit
		dir_rows.push_back(row(8'd7, 32'd1, 32'hFFFF_FFFF, 32'd0, 1, lcm_pkg::ST_OK, 32'd1));
		// slow link clamps at the maximum
		dir_rows.push_back(row(8'd7, 32'hFFFF_FFFF, 32'd1, 32'd999_999, 1,
			lcm_pkg::ST_OK, 32'd65535));
		dir_rows.push_back(row(8'd7, 32'd1, 32'd1, 32'd999_999));
		dir_rows.push_back(row(8'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd500_000));
		dir_rows.push_back(row(8'd7, 32'h8000_0000, 32'h0000_0001, 32'h0008_0000));
		foreach (dir_rows[i])
			send_measurement(dir_rows[i].m, dir_rows[i].has_want, dir_rows[i].want);
		drain();

		// extreme registers: overflow in loss scaling, zero quantum, zero maximum
		write_reg(lcm_pkg::REG_REQUIRED_MASK, 32'd0);
		write_reg(lcm_pkg::REG_REFERENCE_BYTES, 32'hFFFF_FFFF);
		write_reg(lcm_pkg::REG_QUANTUM_US, 32'd0);
		write_reg(lcm_pkg::REG_MAX_LINK_COST, 32'd0);
		send_measurement(row(8'd0, 32'hFFFF_FFFF, 32'd1, 32'd0).m, 1,
			'{status: lcm_pkg::ST_OVERFLOW, cost_value: 0});
		send_measurement(row(8'd0, 32'd5, 32'hFFFF_FFFF, 32'd0).m, 1,
			'{status: lcm_pkg::ST_INVALID, cost_value: 0});
		drain();
		write_reg(lcm_pkg::REG_QUANTUM_US, 32'd1);
		send_measurement(row(8'd0, 32'd5, 32'hFFFF_FFFF, 32'd0).m, 1,
			'{status: lcm_pkg::ST_OK, cost_value: 0});
		drain();
		write_reg(lcm_pkg::REG_REFERENCE_BYTES, 32'd0);
		write_reg(lcm_pkg::REG_MAX_LINK_COST, 32'hFFFF_FFFF);
		send_measurement(row(8'd0, 32'd77, 32'd3, 32'd0).m, 1,
			'{status: lcm_pkg::ST_OK, cost_value: 32'd77});
		send_measurement(row(8'd0, 32'hFFFF_FFFF, 32'd3, 32'd999_999).m, 0, '{default: 0});
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(lcm_pkg::REG_REQUIRED_MASK, (ph == 7) ? 32'hFF : $urandom_range(255));
			write_reg(lcm_pkg::REG_REFERENCE_BYTES, (ph == 6) ? 32'hFFFF_FFFF : rand_word());
			write_reg(lcm_pkg::REG_QUANTUM_US, (ph == 5) ? 32'hFFFF_FFFF
				: (($urandom_range(7) == 0) ? 32'd0 : rand_word()));
			write_reg(lcm_pkg::REG_MAX_LINK_COST, (ph == 4) ? 32'd1 : rand_word());
			calm = (ph == 3);
			for (int i = 0; i < N_RANDOM / 8; i++)
				send_measurement(rand_measurement(), 0, '{default: 0});
			drain();
			calm = 1'b0;
		end

		repeat (PIPE_LAT + 20) @(posedge clk);
		$display("Sent %0d measurements, checked %0d results: %0d ok, %0d invalid, %0d overflow.",
			n_sent, n_results, n_ok, n_inval, n_ovf);
		$display("Register settings covered reset values, zero and all-ones extremes.");
		if (n_errors == 0 && pending_costs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

`default_nettype wire
